// File: rtl/stsir_pkg.sv
// stsir_pkg: field widths, operation and status codes of the slot table.
// No dependencies; used by the top level and its checker.
package stsir_pkg;

   localparam int KEY_W    = 16;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 4;
   localparam int OCC_W    = 5;
   localparam int CFG_W    = 5;

   localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NULL    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd4;

   typedef logic [KEY_W-1:0] key_type;

endpackage

// File: rtl/slot_table_insert_remove.sv
// slot_table_insert_remove: fixed-capacity key table, insert to lowest free slot, remove.
// Depends on stsir_pkg.
//
// Usage
//   Request: drive req_op and req_item_key and raise start; the beat is taken at
//   a rising edge with start high and busy low. busy stays high until the result.
//   Result: rsp_strobe is high for exactly one cycle with rsp_status, rsp_slot and
//   rsp_occupied. The receiver cannot stall; the next request may be taken in the
//   cycle the result is shown.
//   Capacity: csr_valid/csr_data write slots_in_use (csr_ready is always high).
//   Write it only while the block is idle. Values above SLOTS saturate at SLOTS.
// Timing
//   One shared key compare scans one slot per cycle behind a registered memory
//   read, over the slots below the capacity in force; a null key or a zero
//   capacity scans no slot. A new request is taken only after the previous
//   result is shown, as busy is high until then.
// Reset
//   Synchronous, active high: every slot empty, count zero, capacity 16,
//   no result pending. Slot emptiness is held in per-slot valid flops.
module slot_table_insert_remove #(
   parameter int SLOTS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_op,
   input  logic [stsir_pkg::KEY_W-1:0]        req_item_key,
   output logic                               rsp_strobe,
   output logic [stsir_pkg::STATUS_W-1:0]     rsp_status,
   output logic [stsir_pkg::SLOT_W-1:0]       rsp_slot,
   output logic [stsir_pkg::OCC_W-1:0]        rsp_occupied,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [stsir_pkg::CFG_W-1:0]        csr_data
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = (IDX_W >= 5) ? IDX_W + 1 : 6;
   localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]                         state_ff, state_in;
   logic                               op_ff, op_in;
   stsir_pkg::key_type                 key_ff, key_in;
   logic [CNT_W-1:0]                   cap_ff, cap_in;
   logic [CNT_W-1:0]                   cnt_ff, cnt_in;
   logic                               pend_ff, pend_in;
   logic [IDX_W-1:0]                   pidx_ff, pidx_in;
   logic                               hit_ff, hit_in;
   logic [IDX_W-1:0]                   hit_slot_ff, hit_slot_in;
   logic                               empty_ff, empty_in;
   logic [IDX_W-1:0]                   empty_slot_ff, empty_slot_in;
   logic [stsir_pkg::OCC_W-1:0]        count_ff, count_in;
   logic [stsir_pkg::CFG_W-1:0]        sui_ff;
   logic                               rsp_strobe_ff, rsp_strobe_in;
   logic [stsir_pkg::STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [stsir_pkg::SLOT_W-1:0]       rsp_slot_ff, rsp_slot_in;
   logic [stsir_pkg::OCC_W-1:0]        rsp_occ_ff, rsp_occ_in;

   stsir_pkg::key_type                 mem [SLOTS];
   logic [SLOTS-1:0]                   valid_ff;
   stsir_pkg::key_type                 rd_key_ff;
   logic                               rd_vld_ff;
   logic [IDX_W-1:0]                   rd_addr;

   logic                               wr_en;
   logic                               clr_en;
   logic [IDX_W-1:0]                   wr_addr;

   logic [CNT_W-1:0]                   sui_ext;
   logic [CNT_W-1:0]                   cap_now;
   stsir_pkg::key_type                 entry;
   logic                               is_match;
   logic                               is_empty;
   logic                               issue;
   logic [IDX_W-1:0]                   sel_slot;

   assign busy         = (state_ff != S_IDLE);
   assign csr_ready    = 1'b1;
   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_slot     = rsp_slot_ff;
   assign rsp_occupied = rsp_occ_ff;

   assign sui_ext = CNT_W'(sui_ff);
   assign cap_now = (sui_ext > SLOTS_C) ? SLOTS_C : sui_ext;
   assign rd_addr = cnt_ff[IDX_W-1:0];
   assign issue   = (cnt_ff < cap_ff);

   // shared compare unit: one slot per cycle
   assign entry    = rd_vld_ff ? rd_key_ff : '0;
   assign is_match = (entry == key_ff);
   assign is_empty = (entry == '0);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      cap_in        = cap_ff;
      cnt_in        = cnt_ff;
      pend_in       = 1'b0;
      pidx_in       = pidx_ff;
      hit_in        = hit_ff;
      hit_slot_in   = hit_slot_ff;
      empty_in      = empty_ff;
      empty_slot_in = empty_slot_ff;
      count_in      = count_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_occ_in    = rsp_occ_ff;
      wr_en         = 1'b0;
      clr_en        = 1'b0;
      wr_addr       = empty_slot_ff;
      sel_slot      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = req_op;
               key_in   = req_item_key;
               cap_in   = (req_item_key == '0) ? '0 : cap_now;
               cnt_in   = '0;
               hit_in   = 1'b0;
               empty_in = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (issue) begin
               pend_in = 1'b1;
               pidx_in = cnt_ff[IDX_W-1:0];
               cnt_in  = cnt_ff + CNT_W'(1);
            end
            if (pend_ff) begin
               if (is_match && !hit_ff) begin
                  hit_in      = 1'b1;
                  hit_slot_in = pidx_ff;
               end
               if (is_empty && !empty_ff) begin
                  empty_in      = 1'b1;
                  empty_slot_in = pidx_ff;
               end
            end
            if (!issue && !pend_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            rsp_status_in = stsir_pkg::ST_OK;
            if (key_ff == '0) begin
               rsp_status_in = stsir_pkg::ST_NULL;
            end else if (op_ff == stsir_pkg::OP_INSERT) begin
               if (hit_ff) begin
                  rsp_status_in = stsir_pkg::ST_PRESENT;
               end else if (CNT_W'(count_ff) >= cap_ff || !empty_ff) begin
                  rsp_status_in = stsir_pkg::ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = empty_slot_ff;
                  sel_slot = empty_slot_ff;
                  count_in = count_ff + 5'd1;
               end
            end else begin
               if (!hit_ff) begin
                  rsp_status_in = stsir_pkg::ST_ABSENT;
               end else begin
                  clr_en   = 1'b1;
                  wr_addr  = hit_slot_ff;
                  sel_slot = hit_slot_ff;
                  if (count_ff != '0) begin
                     count_in = count_ff - 5'd1;
                  end
               end
            end
            rsp_slot_in   = stsir_pkg::SLOT_W'(sel_slot);
            rsp_occ_in    = count_in;
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_ff       <= 1'b0;
         count_ff      <= '0;
         sui_ff        <= stsir_pkg::CFG_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_ff       <= pend_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid && csr_ready) begin
            sui_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      cap_ff        <= cap_in;
      cnt_ff        <= cnt_in;
      pidx_ff       <= pidx_in;
      hit_ff        <= hit_in;
      hit_slot_ff   <= hit_slot_in;
      empty_ff      <= empty_in;
      empty_slot_ff <= empty_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   // key store, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= key_ff;
      end
      rd_key_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end else if (clr_en) begin
            valid_ff[wr_addr] <= 1'b0;
         end
         rd_vld_ff <= valid_ff[rd_addr];
      end
   end

endmodule

// File: rtl/stsir_checker.sv
// stsir_checker: port-level assertions for slot_table_insert_remove, with its bind.
// Depends on stsir_pkg.
module stsir_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_strobe,
   input logic [stsir_pkg::STATUS_W-1:0] rsp_status,
   input logic [stsir_pkg::SLOT_W-1:0]   rsp_slot
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after request beat");

   a_idle_with_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("busy dropped without a result beat");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result beats back to back");

   a_slot_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != stsir_pkg::ST_OK) |-> (rsp_slot == '0))
      else $error("non-zero slot on refused request");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_status == stsir_pkg::ST_OK || rsp_status == stsir_pkg::ST_NULL ||
                      rsp_status == stsir_pkg::ST_PRESENT ||
                      rsp_status == stsir_pkg::ST_FULL || rsp_status == stsir_pkg::ST_ABSENT))
      else $error("undefined status code");

endmodule

bind slot_table_insert_remove stsir_checker u_stsir_checker (.*);

// File: dv/tb_slot_table_insert_remove.sv
// tb_slot_table_insert_remove: self-checking bench for the slot table, directed table then
// random phases over several capacities; results checked against pinned rows or a predictor.
// Depends on stsir_pkg and slot_table_insert_remove.
module tb_slot_table_insert_remove;

   localparam int SLOTS        = 16;
   localparam int GAP_MAX      = 19;
   localparam int DRAIN_CYCLES = 25;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 1750;
   localparam int POOL_SIZE    = 24;
   localparam int N_ROWS       = 29;

   typedef struct packed {
      logic [stsir_pkg::STATUS_W-1:0] status;
      logic [stsir_pkg::SLOT_W-1:0]   slot;
      logic [stsir_pkg::OCC_W-1:0]    occupied;
   } outcome_type;

   typedef enum logic {ROW_REQ, ROW_CFG} row_kind_type;

   typedef struct packed {
      row_kind_type                   kind;
      logic                           op;
      stsir_pkg::key_type             key;
      logic [stsir_pkg::CFG_W-1:0]    cap;
      logic                           pinned;
      logic [stsir_pkg::STATUS_W-1:0] w_status;
      logic [stsir_pkg::SLOT_W-1:0]   w_slot;
      logic [stsir_pkg::OCC_W-1:0]    w_occ;
   } stim_row_type;

   logic                           clock;
   logic                           reset;
   logic                           start;
   logic                           busy;
   logic                           req_op;
   stsir_pkg::key_type             req_item_key;
   logic                           rsp_strobe;
   logic [stsir_pkg::STATUS_W-1:0] rsp_status;
   logic [stsir_pkg::SLOT_W-1:0]   rsp_slot;
   logic [stsir_pkg::OCC_W-1:0]    rsp_occupied;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [stsir_pkg::CFG_W-1:0]    csr_data;

   // pinned expectation travels with the request beat
   logic        drv_pinned;
   outcome_type drv_want;

   stsir_pkg::key_type          shadow_keys [SLOTS];
   int                          shadow_count;
   logic [stsir_pkg::CFG_W-1:0] shadow_cap;

   outcome_type        awaited_outcomes[$];
   int                 error_count;
   int                 cycle_count;
   bit                 burst_mode;
   stsir_pkg::key_type key_pool [POOL_SIZE];
   stim_row_type       directed_rows [N_ROWS];

   slot_table_insert_remove #(.SLOTS(SLOTS)) i_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_op       (req_op),
      .req_item_key (req_item_key),
      .rsp_strobe   (rsp_strobe),
      .rsp_status   (rsp_status),
      .rsp_slot     (rsp_slot),
      .rsp_occupied (rsp_occupied),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic outcome_type table_outcome(logic op, stsir_pkg::key_type key);
      outcome_type res;
      int          cap;
      int          hit;
      int          free_at;
      cap     = (shadow_cap > SLOTS) ? SLOTS : int'(shadow_cap);
      hit     = -1;
      free_at = -1;
      for (int i = cap - 1; i >= 0; i--) begin
         if (shadow_keys[i] == key) hit = i;
         if (shadow_keys[i] == '0) free_at = i;
      end
      res.status = stsir_pkg::ST_OK;
      res.slot   = '0;
      if (key == '0) begin
         res.status = stsir_pkg::ST_NULL;
      end else if (op == stsir_pkg::OP_INSERT) begin
         if (hit >= 0) begin
            res.status = stsir_pkg::ST_PRESENT;
         end else if (shadow_count >= cap || free_at < 0) begin
            res.status = stsir_pkg::ST_FULL;
         end else begin
            shadow_keys[free_at] = key;
            shadow_count++;
            res.slot = stsir_pkg::SLOT_W'(free_at);
         end
      end else if (hit < 0) begin
         res.status = stsir_pkg::ST_ABSENT;
      end else begin
         shadow_keys[hit] = '0;
         if (shadow_count > 0) shadow_count--;
         res.slot = stsir_pkg::SLOT_W'(hit);
      end
      res.occupied = stsir_pkg::OCC_W'(shadow_count);
      return res;
   endfunction

   always @(posedge clock) begin : monitor
      outcome_type want;
      outcome_type fresh;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else if (!reset) begin
         if (rsp_strobe === 1'b1) begin
            if (awaited_outcomes.size() == 0) begin
               $error("unexpected result: status %0d slot %0d occupied %0d",
                      rsp_status, rsp_slot, rsp_occupied);
               error_count++;
            end else begin
               want = awaited_outcomes.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  error_count++;
               end
               if (rsp_slot !== want.slot) begin
                  $error("slot: expected %0d, got %0d", want.slot, rsp_slot);
                  error_count++;
               end
               if (rsp_occupied !== want.occupied) begin
                  $error("occupied: expected %0d, got %0d", want.occupied, rsp_occupied);
                  error_count++;
               end
            end
         end
         if (csr_valid && csr_ready === 1'b1) shadow_cap = csr_data;
         if (start && busy === 1'b0) begin
            fresh = table_outcome(req_op, req_item_key);
            awaited_outcomes.push_back(drv_pinned ? drv_want : fresh);
         end
      end
   end

   task automatic send_request(logic op, stsir_pkg::key_type key, logic pinned,
                               outcome_type want);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, GAP_MAX);
      @(negedge clock);
      if (gap > 0) begin
         start      <= 1'b0;
         drv_pinned <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start        <= 1'b1;
      req_op       <= op;
      req_item_key <= key;
      drv_pinned   <= pinned;
      drv_want     <= want;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   task automatic write_capacity(logic [stsir_pkg::CFG_W-1:0] value);
      @(negedge clock);
      start      <= 1'b0;
      drv_pinned <= 1'b0;
      while (awaited_outcomes.size() != 0 || busy !== 1'b0) @(negedge clock);
      repeat (3) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      stim_row_type                row;
      outcome_type                 want;
      logic [stsir_pkg::CFG_W-1:0] cap;
      int                          items_sent;
      int                          phase;
      int                          phase_len;
      int                          insert_bias;
      int                          pick;
      logic                        op;
      stsir_pkg::key_type          key;

      clock        = 1'b0;
      reset        = 1'b1;
      start        = 1'b0;
      req_op       = 1'b0;
      req_item_key = '0;
      csr_valid    = 1'b0;
      csr_data     = '0;
      drv_pinned   = 1'b0;
      drv_want     = '0;
      for (int i = 0; i < SLOTS; i++) shadow_keys[i] = '0;
      shadow_count = 0;
      shadow_cap   = stsir_pkg::CFG_RESET;
      error_count  = 0;
      cycle_count  = 0;
      burst_mode   = 1'b0;
      for (int i = 0; i < POOL_SIZE; i++)
         key_pool[i] = stsir_pkg::key_type'($urandom_range(1, 65535));

      directed_rows = '{
         '{ROW_REQ, stsir_pkg::OP_REMOVE, 16'h0000, 5'd0, 1'b1, stsir_pkg::ST_NULL, 4'd0, 5'd0},
         '{ROW_REQ, stsir_pkg::OP_INSERT, 16'h0000, 5'd0, 1'b1, stsir_pkg::ST_NULL, 4'd0, 5'd0},
         '{ROW_REQ, stsir_pkg::OP_REMOVE, 16'hFFFF, 5'd0, 1'b1, stsir_pkg::ST_ABSENT, 4'd0, 5'd0},
         '{ROW_REQ, stsir_pkg::OP_INSERT, 16'hFFFF, 5'd0, 1'b1, stsir_pkg::ST_OK, 4'd0, 5'd1},
         '{ROW_REQ, stsir_pkg::OP_INSERT, 16'hFFFF, 5'd0, 1'b1, stsir_pkg::ST_PRESENT, 4'd0, 5'd1},
         '{ROW_REQ, stsir_pkg::OP_INSERT, 16'h0001, 5'd0, 1'b1, stsir_pkg::ST_OK, 4'd1, 5'd2},
         '{ROW_REQ, stsir_pkg::OP_INSERT, 16'h8000, 5'd0, 1'b1, stsir_pkg::ST_OK, 4'd2, 5'd3},
         '{ROW_REQ, stsir_pkg::OP_REMOVE, 16'h0001, 5'd0, 1'b1, stsir_pkg::ST_OK, 4'd1, 5'd2},
         '{ROW_REQ, stsir_pkg::OP_INSERT, 16'h5555, 5'd0, 1'b1, stsir_pkg::ST_OK, 4'd1, 5'd3},
         '{ROW_REQ, stsir_pkg::OP_INSERT, 16'hAAAA, 5'd0, 1'b1, stsir_pkg::ST_OK, 4'd3, 5'd4},
         '{ROW_REQ, stsir_pkg::OP_REMOVE, 16'hFFFF, 5'd0, 1'b1, stsir_pkg::ST_OK, 4'd0, 5'd3},
         '{ROW_REQ, stsir_pkg::OP_REMOVE, 16'hFFFF, 5'd0, 1'b1, stsir_pkg::ST_ABSENT, 4'd0, 5'd3},
         // capacity below the stored keys: upper slots hidden, count kept
         '{ROW_CFG, stsir_pkg::OP_INSERT, 16'h0000, 5'd2, 1'b0, stsir_pkg::ST_OK, 4'd0, 5'd0},
         '{ROW_REQ, stsir_pkg::OP_INSERT, 16'h1234, 5'd0, 1'b1, stsir_pkg::ST_FULL, 4'd0, 5'd3},
         '{ROW_REQ, stsir_pkg::OP_REMOVE, 16'h8000, 5'd0, 1'b1, stsir_pkg::ST_ABSENT, 4'd0, 5'd3},
         '{ROW_REQ, stsir_pkg::OP_INSERT, 16'h5555, 5'd0, 1'b1, stsir_pkg::ST_PRESENT, 4'd0, 5'd3},
         '{ROW_CFG, stsir_pkg::OP_INSERT, 16'h0000, 5'd0, 1'b0, stsir_pkg::ST_OK, 4'd0, 5'd0},
         '{ROW_REQ, stsir_pkg::OP_INSERT, 16'h0007, 5'd0, 1'b1, stsir_pkg::ST_FULL, 4'd0, 5'd3},
         '{ROW_REQ, stsir_pkg::OP_REMOVE, 16'h5555, 5'd0, 1'b1, stsir_pkg::ST_ABSENT, 4'd0, 5'd3},
         '{ROW_REQ, stsir_pkg::OP_INSERT, 16'h0000, 5'd0, 1'b1, stsir_pkg::ST_NULL, 4'd0, 5'd3},
         // above SLOTS saturates
         '{ROW_CFG, stsir_pkg::OP_INSERT, 16'h0000, 5'd31, 1'b0, stsir_pkg::ST_OK, 4'd0, 5'd0},
         '{ROW_REQ, stsir_pkg::OP_REMOVE, 16'h8000, 5'd0, 1'b1, stsir_pkg::ST_OK, 4'd2, 5'd2},
         '{ROW_REQ, stsir_pkg::OP_INSERT, 16'h1234, 5'd0, 1'b0, stsir_pkg::ST_OK, 4'd0, 5'd0},
         '{ROW_CFG, stsir_pkg::OP_INSERT, 16'h0000, 5'd1, 1'b0, stsir_pkg::ST_OK, 4'd0, 5'd0},
         '{ROW_REQ, stsir_pkg::OP_INSERT, 16'h4321, 5'd0, 1'b0, stsir_pkg::ST_OK, 4'd0, 5'd0},
         '{ROW_REQ, stsir_pkg::OP_REMOVE, 16'h1234, 5'd0, 1'b0, stsir_pkg::ST_OK, 4'd0, 5'd0},
         '{ROW_REQ, stsir_pkg::OP_INSERT, 16'h4321, 5'd0, 1'b0, stsir_pkg::ST_OK, 4'd0, 5'd0},
         '{ROW_CFG, stsir_pkg::OP_INSERT, 16'h0000, 5'd16, 1'b0, stsir_pkg::ST_OK, 4'd0, 5'd0},
         '{ROW_REQ, stsir_pkg::OP_INSERT, 16'hFFFE, 5'd0, 1'b0, stsir_pkg::ST_OK, 4'd0, 5'd0}
      };

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < N_ROWS; r++) begin
         row = directed_rows[r];
         if (row.kind == ROW_CFG) begin
            write_capacity(row.cap);
         end else begin
            want.status   = row.w_status;
            want.slot     = row.w_slot;
            want.occupied = row.w_occ;
            send_request(row.op, row.key, row.pinned, want);
         end
      end

      items_sent = 0;
      phase      = 0;
      while (items_sent < RANDOM_ITEMS) begin
         case (phase)
            0: cap = 5'd16;
            1: cap = 5'd0;
            2: cap = 5'd31;
            3: cap = 5'd1;
            default: begin
               if ($urandom_range(0, 9) < 3) cap = stsir_pkg::CFG_W'($urandom_range(17, 31));
               else cap = stsir_pkg::CFG_W'($urandom_range(0, 16));
            end
         endcase
         write_capacity(cap);
         for (int i = 0; i < 4; i++)
            key_pool[$urandom_range(0, POOL_SIZE - 1)] =
               stsir_pkg::key_type'($urandom_range(1, 65535));
         case ($urandom_range(0, 2))
            0: insert_bias = 75;
            1: insert_bias = 50;
            default: insert_bias = 25;
         endcase
         burst_mode = ($urandom_range(0, 3) == 0);
         phase_len  = (cap == 5'd0) ? 20 : $urandom_range(40, 120);
         for (int n = 0; n < phase_len; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) key = '0;
            else if (pick < 12) key = stsir_pkg::key_type'($urandom_range(0, 65535));
            else key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            op = ($urandom_range(0, 99) < insert_bias) ? stsir_pkg::OP_INSERT
                                                       : stsir_pkg::OP_REMOVE;
            send_request(op, key, 1'b0, '0);
            items_sent++;
         end
         phase++;
      end

      @(negedge clock);
      start <= 1'b0;
      while (awaited_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
